// ===== rtl/image_strip_gap_aligner_assert.svh =====
// assertion macros for the image strip gap aligner
// used by the top level only, no other dependencies
`ifndef IMAGE_STRIP_GAP_ALIGNER_ASSERT_SVH
`define IMAGE_STRIP_GAP_ALIGNER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ISGA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ISGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ISGA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`define ISGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/isga_pkg.sv =====
// shared types and constants of the image strip gap aligner
// no dependencies
package isga_pkg;

    localparam int BLK_W       = 8;
    localparam int PKT_SEQ_W   = 14;
    localparam int CNT_W       = 16;
    localparam int DVSR_W      = 8;
    localparam int TAB_DEPTH   = 1 << BLK_W;
    localparam int Q_DEPTH     = 2;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 40;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int DEF_BLOCKS_PER_LINE    = 196;
    localparam int DEF_BLOCKS_PER_STRIP   = 14;
    localparam int DEF_STRIPS_PER_LINE    = 14;
    localparam int DEF_PACKETS_PER_PERIOD = 43;
    localparam int DEF_PACKET_SEQ_RANGE   = 16384;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic out_wait;
    } t_back_stat;

endpackage

// ===== rtl/isga_div.sv =====
// exact division by a constant through a reciprocal multiplication
// no dependencies
module isga_div #(
    parameter int DIV_W   = 16,
    parameter int DIVISOR = 3
) (
    input  logic [DIV_W-1:0] i_dividend,
    output logic [DIV_W-1:0] o_quotient
);

    // with shift = width + ceil(log2 d) and the rounded-up reciprocal the
    // truncated product equals the quotient for every dividend of DIV_W bits
    localparam int SHIFT  = DIV_W + $clog2(DIVISOR);
    localparam int PROD_W = SHIFT + DIV_W;

    localparam logic [PROD_W-1:0] MULT =
        PROD_W'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [PROD_W-1:0] prod;

    assign prod       = PROD_W'(i_dividend) * MULT;
    assign o_quotient = prod[PROD_W-1:SHIFT];

endmodule

// ===== rtl/isga_queue.sv =====
// two-entry queue between the classifying front and the sequencing back
// depends on isga_pkg
module isga_queue
    import isga_pkg::*;
#(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output t_q_stat      o_stat
);

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_B = $clog2(Q_DEPTH + 1);

    logic [W-1:0]     r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_B-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rptr];
    assign o_stat.full  = r_count == CNT_B'(Q_DEPTH);
    assign o_stat.empty = r_count == '0;

endmodule

// ===== rtl/isga_front.sv =====
// input side: takes a strip, rounds its block number, reduces the packet number
// depends on isga_pkg, feeds isga_queue
module isga_front
    import isga_pkg::*;
#(
    parameter int BLOCKS_PER_LINE  = DEF_BLOCKS_PER_LINE,
    parameter int BLOCKS_PER_STRIP = DEF_BLOCKS_PER_STRIP,
    parameter int PACKET_SEQ_RANGE = DEF_PACKET_SEQ_RANGE
) (
    input  logic                                         i_s_tvalid,
    output logic                                         o_s_tready,
    input  logic [IN_TDATA_W-1:0]                        i_s_tdata,
    input  logic                                         i_s_tuser,
    input  t_q_stat                                      i_q_stat,
    output logic                                         o_q_push,
    output logic [2*BLK_W+$clog2(PACKET_SEQ_RANGE):0]    o_q_data
);

    localparam int PKT_W     = $clog2(PACKET_SEQ_RANGE);
    localparam int RED_W     = PKT_SEQ_W + 1;
    // conditional subtracts of R << k needed to bring a 14-bit value below R
    localparam int RED_STEPS = PKT_SEQ_W - ($clog2(PACKET_SEQ_RANGE + 1) - 1);

    logic [BLK_W-1:0]     rb_tab  [TAB_DEPTH];
    logic [BLK_W-1:0]     rbm_tab [TAB_DEPTH];
    logic [BLK_W-1:0]     blk;
    logic [PKT_SEQ_W-1:0] pkt;
    logic [RED_W-1:0]     v_red;

    for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tab
        assign rb_tab[gi]  = BLK_W'(gi - gi % BLOCKS_PER_STRIP);
        assign rbm_tab[gi] = BLK_W'((gi - gi % BLOCKS_PER_STRIP) % BLOCKS_PER_LINE);
    end

    assign blk = i_s_tdata[BLK_W-1:0];
    assign pkt = i_s_tdata[BLK_W+PKT_SEQ_W-1:BLK_W];

    always_comb begin
        v_red = RED_W'(pkt);
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            if (v_red >= RED_W'(PACKET_SEQ_RANGE << k)) begin
                v_red = v_red - RED_W'(PACKET_SEQ_RANGE << k);
            end
        end
    end

    assign o_s_tready = !i_q_stat.full;
    assign o_q_push   = i_s_tvalid && !i_q_stat.full;
    // entry from the lowest bit: rounded block, rounded block mod line, packet, present
    assign o_q_data   = {i_s_tuser, PKT_W'(v_red), rbm_tab[blk], rb_tab[blk]};

endmodule

// ===== rtl/isga_back.sv =====
// sequencer: gap count, line placement, state update and output register
// depends on isga_pkg and isga_div
module isga_back
    import isga_pkg::*;
#(
    parameter int BLOCKS_PER_LINE    = DEF_BLOCKS_PER_LINE,
    parameter int BLOCKS_PER_STRIP   = DEF_BLOCKS_PER_STRIP,
    parameter int STRIPS_PER_LINE    = DEF_STRIPS_PER_LINE,
    parameter int PACKETS_PER_PERIOD = DEF_PACKETS_PER_PERIOD,
    parameter int PACKET_SEQ_RANGE   = DEF_PACKET_SEQ_RANGE
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  t_q_stat                                   i_q_stat,
    input  logic [2*BLK_W+$clog2(PACKET_SEQ_RANGE):0] i_q_data,
    output logic                                      o_q_pop,
    output t_back_stat                                o_stat,
    output logic                                      o_m_tvalid,
    input  logic                                      i_m_tready,
    output logic [OUT_TDATA_W-1:0]                    o_m_tdata,
    output logic                                      o_m_tuser
);

    localparam int PKT_W    = $clog2(PACKET_SEQ_RANGE);
    localparam int LOST_MAX = (BLOCKS_PER_LINE - 1) / BLOCKS_PER_STRIP
                            + ((PACKET_SEQ_RANGE - 1) / PACKETS_PER_PERIOD) * STRIPS_PER_LINE;
    localparam int LOST_W   = $clog2(LOST_MAX + 1);
    localparam int SUM_W    = ((LOST_W > CNT_W) ? LOST_W : CNT_W) + 1;
    localparam int PERIOD   = (BLOCKS_PER_LINE + BLOCKS_PER_STRIP - 1) / BLOCKS_PER_STRIP;
    localparam bit ADV_UP   = PACKETS_PER_PERIOD >= STRIPS_PER_LINE;
    localparam int ADV_D    = ADV_UP ? PACKETS_PER_PERIOD - STRIPS_PER_LINE
                                     : STRIPS_PER_LINE - PACKETS_PER_PERIOD;

    localparam logic [PKT_W:0] R_EXT = (PKT_W + 1)'(PACKET_SEQ_RANGE);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PDIV = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_CHK  = 6'b001000,
        ST_WDIV = 6'b010000,
        ST_FIN  = 6'b100000
    } t_back_state;

    t_back_state r_state, n_state;

    // kept across strips
    logic [BLK_W-1:0] r_col, n_col;
    logic [PKT_W-1:0] r_last, n_last;
    logic             r_seen, n_seen;
    logic [CNT_W-1:0] r_line, n_line;
    logic             r_out_valid, n_out_valid;

    // per strip
    logic [BLK_W-1:0]       r_rb, n_rb;
    logic [PKT_W-1:0]       r_pkt, n_pkt;
    logic                   r_present, n_present;
    logic [PKT_W-1:0]       r_pdelta, n_pdelta;
    logic [BLK_W-1:0]       r_bdiv, n_bdiv;
    logic [BLK_W-1:0]       r_first, n_first;
    logic [PKT_W-1:0]       r_lines, n_lines;
    logic [LOST_W-1:0]      r_lost, n_lost;
    logic [LOST_W-1:0]      r_wdiff, n_wdiff;
    logic [LOST_W-1:0]      r_wraps, n_wraps;
    logic [OUT_TDATA_W-1:0] r_out_tdata, n_out_tdata;
    logic                   r_out_tuser, n_out_tuser;

    logic [BLK_W-1:0]  bdiv_tab  [TAB_DEPTH];
    logic [BLK_W-1:0]  first_tab [TAB_DEPTH];

    logic [BLK_W-1:0]  q_rb, q_rbm;
    logic [PKT_W-1:0]  q_pkt;
    logic              q_present;
    logic [PKT_W-1:0]  pdelta;
    logic [BLK_W-1:0]  bdelta;
    logic [PKT_W:0]    adv_sum;
    logic [PKT_W-1:0]  adv;
    logic [SUM_W-1:0]  line_sum;
    logic [CNT_W-1:0]  line_new;
    logic [CNT_W-1:0]  blank;
    logic              line_end;
    logic              out_free;

    logic [PKT_W-1:0]  pkt_quo;
    logic [LOST_W-1:0] wrap_quo;

    for (genvar gi = 0; gi < TAB_DEPTH; gi++) begin : g_tab
        assign bdiv_tab[gi]  = BLK_W'(gi / BLOCKS_PER_STRIP);
        assign first_tab[gi] = (gi >= BLOCKS_PER_LINE) ? BLK_W'(1) :
            BLK_W'((BLOCKS_PER_LINE - gi + BLOCKS_PER_STRIP - 1) / BLOCKS_PER_STRIP);
    end

    assign q_rb      = i_q_data[BLK_W-1:0];
    assign q_rbm     = i_q_data[2*BLK_W-1:BLK_W];
    assign q_pkt     = i_q_data[2*BLK_W+PKT_W-1:2*BLK_W];
    assign q_present = i_q_data[2*BLK_W+PKT_W];

    // packets strictly between the last one and this one, modulo the range
    assign pdelta = (q_pkt > r_last) ? PKT_W'(q_pkt - r_last - 1'b1)
                  : PKT_W'((PKT_W + 1)'(q_pkt) + R_EXT - (PKT_W + 1)'(r_last) - 1'b1);
    // column always sits below the line length
    assign bdelta = (q_rbm < r_col)
                  ? BLK_W'((BLK_W + 1)'(q_rbm) + (BLK_W + 1)'(BLOCKS_PER_LINE) - (BLK_W + 1)'(r_col))
                  : q_rbm - r_col;

    // packet number carried to the next line start
    always_comb begin
        adv_sum = '0;
        if (ADV_UP) begin
            adv_sum = (PKT_W + 1)'(r_pkt) + (PKT_W + 1)'(ADV_D);
            adv = (adv_sum >= R_EXT) ? PKT_W'(adv_sum - R_EXT) : PKT_W'(adv_sum);
        end else if (r_pkt >= PKT_W'(ADV_D)) begin
            adv = r_pkt - PKT_W'(ADV_D);
        end else begin
            adv = PKT_W'((PKT_W + 1)'(r_pkt) + R_EXT - (PKT_W + 1)'(ADV_D));
        end
    end

    assign line_sum = SUM_W'(r_line) + SUM_W'(r_wraps);
    assign line_new = (line_sum > SUM_W'(CNT_MAX)) ? CNT_MAX : line_sum[CNT_W-1:0];
    assign blank    = (SUM_W'(r_lost) > SUM_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(r_lost);
    assign line_end = (BLK_W + 1)'(r_rb) + (BLK_W + 1)'(BLOCKS_PER_STRIP)
                   >= (BLK_W + 1)'(BLOCKS_PER_LINE);
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        n_last       = r_last;
        n_seen       = r_seen;
        n_line       = r_line;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_rb         = r_rb;
        n_pkt        = r_pkt;
        n_present    = r_present;
        n_pdelta     = r_pdelta;
        n_bdiv       = r_bdiv;
        n_first      = r_first;
        n_lines      = r_lines;
        n_lost       = r_lost;
        n_wdiff      = r_wdiff;
        n_wraps      = r_wraps;
        n_out_tdata  = r_out_tdata;
        n_out_tuser  = r_out_tuser;
        o_q_pop      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_pop   = 1'b1;
                    n_rb      = q_rb;
                    n_pkt     = q_pkt;
                    n_present = q_present;
                    n_pdelta  = pdelta;
                    n_bdiv    = bdiv_tab[bdelta];
                    n_first   = first_tab[r_col];
                    n_state   = ST_PDIV;
                end
            end
            ST_PDIV: begin
                // first strip after reset counts no lost lines
                n_lines = r_seen ? pkt_quo : '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_lost  = LOST_W'(LOST_W'(r_lines) * LOST_W'(STRIPS_PER_LINE))
                        + LOST_W'(r_bdiv);
                n_state = ST_CHK;
            end
            ST_CHK: begin
                if (SUM_W'(r_lost) < SUM_W'(r_first)) begin
                    n_wraps = '0;
                    n_state = ST_FIN;
                end else begin
                    n_wdiff = r_lost - LOST_W'(r_first);
                    n_state = ST_WDIV;
                end
            end
            ST_WDIV: begin
                n_wraps = wrap_quo + 1'b1;
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = {r_rb, line_new, blank};
                    n_out_tuser = !r_present;
                    n_seen      = 1'b1;
                    if (line_end) begin
                        n_col  = '0;
                        n_last = adv;
                        n_line = (line_new == CNT_MAX) ? CNT_MAX : line_new + 1'b1;
                    end else begin
                        n_col  = BLK_W'((BLK_W + 1)'(r_rb) + (BLK_W + 1)'(BLOCKS_PER_STRIP));
                        n_last = r_pkt;
                        n_line = line_new;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_last      <= '0;
            r_seen      <= 1'b0;
            r_line      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_last      <= n_last;
            r_seen      <= n_seen;
            r_line      <= n_line;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rb        <= n_rb;
        r_pkt       <= n_pkt;
        r_present   <= n_present;
        r_pdelta    <= n_pdelta;
        r_bdiv      <= n_bdiv;
        r_first     <= n_first;
        r_lines     <= n_lines;
        r_lost      <= n_lost;
        r_wdiff     <= n_wdiff;
        r_wraps     <= n_wraps;
        r_out_tdata <= n_out_tdata;
        r_out_tuser <= n_out_tuser;
    end

    isga_div #(
        .DIV_W   (PKT_W),
        .DIVISOR (PACKETS_PER_PERIOD)
    ) u_pkt_div (
        .i_dividend (r_pdelta),
        .o_quotient (pkt_quo)
    );

    isga_div #(
        .DIV_W   (LOST_W),
        .DIVISOR (PERIOD)
    ) u_wrap_div (
        .i_dividend (r_wdiff),
        .o_quotient (wrap_quo)
    );

    assign o_stat.busy     = r_state != ST_IDLE;
    assign o_stat.out_wait = (r_state == ST_FIN) && !out_free;
    assign o_m_tvalid      = r_out_valid;
    assign o_m_tdata       = r_out_tdata;
    assign o_m_tuser       = r_out_tuser;

endmodule

// ===== rtl/image_strip_gap_aligner.sv =====
// top level of the image strip gap aligner
// depends on isga_pkg, isga_front, isga_queue, isga_back and the assertion header

// One strip goes in per transfer and exactly one result comes out per strip, in order.
// The back end steps a strip through taking it from the queue, packet gap division,
// lost strip count, line end check and result register; when the blank strips cross
// a line end, the wrap count needs a division of its own before the result register.
// Both divisions are reciprocal multiplications by constants. The back end takes no
// new strip from the queue before it has finished the last one. A two-entry queue
// behind the input lets two further strips be taken while one is in work, and the
// output register lets the next strip go up to its final step while a result waits.
`include "image_strip_gap_aligner_assert.svh"

module image_strip_gap_aligner
    import isga_pkg::*;
#(
    parameter int BLOCKS_PER_LINE    = DEF_BLOCKS_PER_LINE,
    parameter int BLOCKS_PER_STRIP   = DEF_BLOCKS_PER_STRIP,
    parameter int STRIPS_PER_LINE    = DEF_STRIPS_PER_LINE,
    parameter int PACKETS_PER_PERIOD = DEF_PACKETS_PER_PERIOD,
    parameter int PACKET_SEQ_RANGE   = DEF_PACKET_SEQ_RANGE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // block_seq [7:0], packet_seq [21:8], zero [23:22]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // strip_present
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // blank_strips [15:0], line_index [31:16], column_block [39:32]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // is_blank
    output logic                   o_m_axis_tuser
);

    localparam int ENTRY_W = 2 * BLK_W + $clog2(PACKET_SEQ_RANGE) + 1;

    t_q_stat            w_q_stat;
    t_back_stat         w_back_stat;
    logic               w_q_push;
    logic               w_q_pop;
    logic [ENTRY_W-1:0] w_q_wdata;
    logic [ENTRY_W-1:0] w_q_rdata;

    isga_front #(
        .BLOCKS_PER_LINE  (BLOCKS_PER_LINE),
        .BLOCKS_PER_STRIP (BLOCKS_PER_STRIP),
        .PACKET_SEQ_RANGE (PACKET_SEQ_RANGE)
    ) u_front (
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .i_s_tuser  (i_s_axis_tuser),
        .i_q_stat   (w_q_stat),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_wdata)
    );

    isga_queue #(
        .W (ENTRY_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_data  (w_q_rdata),
        .o_stat  (w_q_stat)
    );

    isga_back #(
        .BLOCKS_PER_LINE    (BLOCKS_PER_LINE),
        .BLOCKS_PER_STRIP   (BLOCKS_PER_STRIP),
        .STRIPS_PER_LINE    (STRIPS_PER_LINE),
        .PACKETS_PER_PERIOD (PACKETS_PER_PERIOD),
        .PACKET_SEQ_RANGE   (PACKET_SEQ_RANGE)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_stat   (w_q_stat),
        .i_q_data   (w_q_rdata),
        .o_q_pop    (w_q_pop),
        .o_stat     (w_back_stat),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata),
        .o_m_tuser  (o_m_axis_tuser)
    );

    `ISGA_ASSERT_IMPLY(a_no_push_full, i_clk, i_rst_n, w_q_push, !w_q_stat.full, "push into full queue")
    `ISGA_ASSERT_IMPLY(a_no_pop_empty, i_clk, i_rst_n, w_q_pop, !w_q_stat.empty, "pop from empty queue")
    `ISGA_ASSERT_NEXT(a_pop_starts_work, i_clk, i_rst_n, w_q_pop, w_back_stat.busy, "popped strip not in work")
    `ISGA_ASSERT_IMPLY(a_wait_needs_stall, i_clk, i_rst_n, w_back_stat.out_wait, o_m_axis_tvalid && !i_m_axis_tready, "result held without a stalled output")

endmodule
